[rtl/scrm_pkg.sv]
// Shared types and constants for the scale / clamp / range-map pipeline.
// No dependencies; every other file in rtl/ refers to this package by scoped names.

package scrm_pkg;

	// data width of every signed fixed-point field
	localparam int DW = 32;

	// divider: quotient bits resolved per stage, and number of stages
	localparam int DIV_STEP   = 4;
	localparam int DIV_STAGES = DW / DIV_STEP;

	// operating modes (mode register)
	localparam logic [1:0] MODE_SCALE = 2'd0;
	localparam logic [1:0] MODE_CLAMP = 2'd1;
	localparam logic [1:0] MODE_MAP   = 2'd2;

	// result status codes
	localparam logic [1:0] ST_SCALED  = 2'd0;
	localparam logic [1:0] ST_CLAMPED = 2'd1;
	localparam logic [1:0] ST_MAPPED  = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_MODE    = 3'd0,
		REG_COEF_A  = 3'd1,
		REG_COEF_B  = 3'd2,
		REG_OUT_MIN = 3'd3,
		REG_OUT_MAX = 3'd4
	} cfg_reg_t;

	// which end of the map the result takes, or the divided step
	typedef enum logic [1:0] {
		SEL_MIN = 2'd0,
		SEL_MAX = 2'd1,
		SEL_DIV = 2'd2
	} map_sel_t;

	// configuration as seen by the datapath
	typedef struct packed {
		logic [1:0]    mode;
		logic [DW-1:0] coef_a;
		logic [DW-1:0] coef_b;
		logic [DW-1:0] out_min;
		logic [DW-1:0] out_max;
	} cfg_t;

	// fields that ride alongside the divider
	typedef struct packed {
		logic [DW-1:0] src;
		logic [DW-1:0] res;
		logic          quality;
		logic [1:0]    status;
		map_sel_t      sel;
		logic          span_neg;
	} side_t;

	// divider working set: partial remainder, dividend/quotient shifter, divisor
	typedef struct packed {
		logic [DW-1:0] rem;
		logic [DW-1:0] lo;
		logic [DW-1:0] div;
	} div_t;

endpackage

[rtl/scrm_if.sv]
// Valid/ready channel interfaces for the input samples and the conditioned results.
// Depends on scrm_pkg for the data width.

interface scrm_in_if;
	logic                       valid;
	logic                       ready;
	logic                       input_present;
	logic                       input_is_binary;
	logic                       binary_level;
	logic signed [scrm_pkg::DW-1:0] sample;

	modport source (output valid, input ready,
		output input_present, output input_is_binary, output binary_level, output sample);
	modport sink (input valid, output ready,
		input input_present, input input_is_binary, input binary_level, input sample);
endinterface

interface scrm_out_if;
	logic                       valid;
	logic                       ready;
	logic signed [scrm_pkg::DW-1:0] source_value;
	logic signed [scrm_pkg::DW-1:0] result_value;
	logic                       quality;
	logic [1:0]                 status;

	modport source (output valid, input ready,
		output source_value, output result_value, output quality, output status);
	modport sink (input valid, output ready,
		input source_value, input result_value, input quality, input status);
endinterface

[rtl/scrm_front.sv]
// Front end of the pipeline, stages 1 to 5: source select, scale, clamp, map set-up.
// Depends on scrm_pkg (cfg_t, side_t, div_t, mode and status codes).

module scrm_front #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  scrm_pkg::cfg_t       cfg,
	input  logic                 in_vld,
	input  logic                 in_present,
	input  logic                 in_is_binary,
	input  logic                 in_level,
	input  logic [scrm_pkg::DW-1:0] in_sample,
	output logic                 vld_o,
	output scrm_pkg::side_t      side_o,
	output scrm_pkg::div_t       div_o
);

	localparam int DW = scrm_pkg::DW;
	localparam int SW = 2 * DW + 2;
	localparam logic signed [DW-1:0] ONE  = DW'(1) << FRAC_BITS;
	localparam logic signed [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);
	localparam logic signed [SW-1:0] SMAX = SW'(64'sd2147483647);
	localparam logic signed [SW-1:0] SMIN = -SW'(64'sd2147483648);

	logic signed [DW-1:0] coef_a;
	logic signed [DW-1:0] coef_b;
	logic signed [DW-1:0] out_min;
	logic signed [DW-1:0] out_max;

	assign coef_a  = cfg.coef_a;
	assign coef_b  = cfg.coef_b;
	assign out_min = cfg.out_min;
	assign out_max = cfg.out_max;

	// ---------------- stage 1: effective source and status ----------------
	logic                 vld_s1;
	logic signed [DW-1:0] src_s1;
	logic                 qual_s1;
	logic [1:0]           stat_s1;
	logic signed [DW-1:0] src_c;
	logic [1:0]           stat_c;

	always_comb begin
		if (!in_present) begin
			src_c = '0;
		end else if (in_is_binary) begin
			src_c = in_level ? ONE : '0;
		end else begin
			src_c = in_sample;
		end
		if (!in_present) begin
			stat_c = scrm_pkg::ST_MISSING;
		end else begin
			case (cfg.mode)
				scrm_pkg::MODE_CLAMP: stat_c = scrm_pkg::ST_CLAMPED;
				scrm_pkg::MODE_MAP:   stat_c = scrm_pkg::ST_MAPPED;
				default:              stat_c = scrm_pkg::ST_SCALED;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			src_s1  <= src_c;
			qual_s1 <= !in_present;
			stat_s1 <= stat_c;
		end
	end

	// ---------------- stage 2: scale product, clamp, map differences ----------------
	logic                    vld_s2;
	logic signed [DW-1:0]    src_s2;
	logic                    qual_s2;
	logic [1:0]              stat_s2;
	logic signed [2*DW-1:0]  prod_s2;
	logic signed [DW-1:0]    clp_s2;
	logic signed [DW:0]      num_s2;
	logic signed [DW:0]      den_s2;
	logic signed [DW:0]      span_s2;
	logic signed [DW-1:0]    lo_c;
	logic signed [DW-1:0]    hi_c;
	logic signed [DW-1:0]    clp_c;

	// ordered limits, then clamp
	always_comb begin
		lo_c = (coef_a <= coef_b) ? coef_a : coef_b;
		hi_c = (coef_a <= coef_b) ? coef_b : coef_a;
		if (src_s1 < lo_c) begin
			clp_c = lo_c;
		end else if (src_s1 > hi_c) begin
			clp_c = hi_c;
		end else begin
			clp_c = src_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			src_s2  <= src_s1;
			qual_s2 <= qual_s1;
			stat_s2 <= stat_s1;
			prod_s2 <= src_s1 * coef_a;
			clp_s2  <= clp_c;
			num_s2  <= (DW+1)'(src_s1) - (DW+1)'(coef_a);
			den_s2  <= (DW+1)'(coef_b) - (DW+1)'(coef_a);
			span_s2 <= (DW+1)'(out_max) - (DW+1)'(out_min);
		end
	end

	// ---------------- stage 3: scale sum, map magnitudes ----------------
	logic                    vld_s3;
	logic signed [DW-1:0]    src_s3;
	logic                    qual_s3;
	logic [1:0]              stat_s3;
	logic signed [SW-1:0]    sum_s3;
	logic signed [DW-1:0]    clp_s3;
	logic signed [DW:0]      num_s3;
	logic [DW-1:0]           den_s3;
	logic [DW-1:0]           span_s3;
	logic                    span_neg_s3;
	logic                    den_zero_s3;
	logic signed [DW:0]      den_abs_c;
	logic signed [DW:0]      span_abs_c;

	// a negative denominator flips both signs so the ratio is unchanged
	assign den_abs_c  = den_s2[DW] ? -den_s2 : den_s2;
	assign span_abs_c = span_s2[DW] ? -span_s2 : span_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			src_s3      <= src_s2;
			qual_s3     <= qual_s2;
			stat_s3     <= stat_s2;
			sum_s3      <= SW'(prod_s2) + (SW'(coef_b) <<< FRAC_BITS) + HALF;
			clp_s3      <= clp_s2;
			num_s3      <= den_s2[DW] ? -num_s2 : num_s2;
			den_s3      <= den_abs_c[DW-1:0];
			span_s3     <= span_abs_c[DW-1:0];
			span_neg_s3 <= span_s2[DW];
			den_zero_s3 <= (den_s2 == '0);
		end
	end

	// ---------------- stage 4: scale round/saturate, map case, map product ----------------
	logic                    vld_s4;
	scrm_pkg::side_t         side_s4;
	logic [2*DW-1:0]         prod_s4;
	logic [DW-1:0]           den_s4;
	logic signed [SW-1:0]    shr_c;
	logic signed [DW-1:0]    sat_c;
	scrm_pkg::map_sel_t      sel_c;
	logic [DW-1:0]           res_c;

	// floor shift then saturate to the signed data width
	always_comb begin
		shr_c = sum_s3 >>> FRAC_BITS;
		if (shr_c > SMAX) begin
			sat_c = SMAX[DW-1:0];
		end else if (shr_c < SMIN) begin
			sat_c = SMIN[DW-1:0];
		end else begin
			sat_c = shr_c[DW-1:0];
		end
	end

	// equal limits or ratio at or below zero give out_min, at or above one out_max
	always_comb begin
		if (den_zero_s3 || num_s3 <= 0) begin
			sel_c = scrm_pkg::SEL_MIN;
		end else if (num_s3 >= $signed({1'b0, den_s3})) begin
			sel_c = scrm_pkg::SEL_MAX;
		end else begin
			sel_c = scrm_pkg::SEL_DIV;
		end
	end

	always_comb begin
		case (stat_s3)
			scrm_pkg::ST_SCALED:  res_c = sat_c;
			scrm_pkg::ST_CLAMPED: res_c = clp_s3;
			default:              res_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4.src      <= src_s3;
			side_s4.res      <= res_c;
			side_s4.quality  <= qual_s3;
			side_s4.status   <= stat_s3;
			side_s4.sel      <= sel_c;
			side_s4.span_neg <= span_neg_s3;
			prod_s4          <= num_s3[DW-1:0] * span_s3;
			den_s4           <= den_s3;
		end
	end

	// ---------------- stage 5: rounding bias, divider load ----------------
	logic            vld_s5;
	scrm_pkg::side_t side_s5;
	scrm_pkg::div_t  div_s5;
	logic [2*DW-1:0] dvd_c;

	// product plus half the divisor gives round to nearest, halves up
	assign dvd_c = prod_s4 + (2*DW)'(den_s4 >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5    <= side_s4;
			div_s5.rem <= dvd_c[2*DW-1:DW];
			div_s5.lo  <= dvd_c[DW-1:0];
			div_s5.div <= den_s4;
		end
	end

	assign vld_o  = vld_s5;
	assign side_o = side_s5;
	assign div_o  = div_s5;

endmodule

[rtl/scrm_div_stage.sv]
// One stage of the restoring divider: resolves DIV_STEP quotient bits per cycle while adv is high.
// Depends on scrm_pkg (div_t, side_t, DIV_STEP).

module scrm_div_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            vld_i,
	input  scrm_pkg::side_t side_i,
	input  scrm_pkg::div_t  div_i,
	output logic            vld_o,
	output scrm_pkg::side_t side_o,
	output scrm_pkg::div_t  div_o
);

	localparam int DW = scrm_pkg::DW;

	logic            vld_sn;
	scrm_pkg::side_t side_sn;
	scrm_pkg::div_t  div_sn;
	logic [DW-1:0]   rem_c;
	logic [DW-1:0]   lo_c;
	logic [DW:0]     trial_c;

	// shift one dividend bit into the remainder, subtract where it fits;
	// quotient bits fill the low end as dividend bits leave it
	always_comb begin
		rem_c   = div_i.rem;
		lo_c    = div_i.lo;
		trial_c = '0;
		for (int i = 0; i < scrm_pkg::DIV_STEP; i++) begin
			trial_c = {rem_c, lo_c[DW-1]};
			lo_c    = lo_c << 1;
			if (trial_c >= {1'b0, div_i.div}) begin
				trial_c = trial_c - {1'b0, div_i.div};
				lo_c[0] = 1'b1;
			end
			rem_c = trial_c[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= 1'b0;
		end else if (adv) begin
			vld_sn <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_sn    <= side_i;
			div_sn.rem <= rem_c;
			div_sn.lo  <= lo_c;
			div_sn.div <= div_i.div;
		end
	end

	assign vld_o  = vld_sn;
	assign side_o = side_sn;
	assign div_o  = div_sn;

endmodule

[rtl/scale_clamp_range_map_top.sv]
// Top level of the scale / clamp / range-map conditioner: config registers,
// front end, divider chain and output stage. Depends on scrm_pkg, scrm_if,
// scrm_front and scrm_div_stage.
//
//  channel  | kind          | handshake          | payload
//  ---------+---------------+--------------------+------------------------------------------
//  in_ch    | scrm_in_if    | valid/ready        | input_present, input_is_binary,
//           |               |                    | binary_level, sample
//  out_ch   | scrm_out_if   | valid/ready        | source_value, result_value, quality, status
//  cfg      | write port    | cfg_we             | cfg_index, cfg_data
//
// One sample enters per cycle while the pipeline advances, and passes 14 register stages:
// five front stages, eight divider stages of four quotient bits, one output stage. Its
// result is offered on out_ch once it reaches the output stage register.
// The whole pipeline advances together; it holds while a result waits and out_ch.ready
// is low, so in_ch.ready follows out_ch.ready whenever the output stage is full.
// Reset clears the valid bits and loads the register defaults (gain 1.0, all else zero).

module scale_clamp_range_map_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_index,
	input  logic [scrm_pkg::DW-1:0]    cfg_data,
	scrm_in_if.sink                    in_ch,
	scrm_out_if.source                 out_ch
);

	localparam int DW  = scrm_pkg::DW;
	localparam int NDS = scrm_pkg::DIV_STAGES;
	localparam logic [DW-1:0] COEF_A_RST = DW'(1) << FRAC_BITS;

	// ---------------- configuration registers ----------------
	logic [1:0]    mode_q;
	logic [DW-1:0] coef_a_q;
	logic [DW-1:0] coef_b_q;
	logic [DW-1:0] out_min_q;
	logic [DW-1:0] out_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= scrm_pkg::MODE_SCALE;
			coef_a_q  <= COEF_A_RST;
			coef_b_q  <= '0;
			out_min_q <= '0;
			out_max_q <= '0;
		end else if (cfg_we) begin
			case (scrm_pkg::cfg_reg_t'(cfg_index))
				scrm_pkg::REG_MODE:    mode_q    <= cfg_data[1:0];
				scrm_pkg::REG_COEF_A:  coef_a_q  <= cfg_data;
				scrm_pkg::REG_COEF_B:  coef_b_q  <= cfg_data;
				scrm_pkg::REG_OUT_MIN: out_min_q <= cfg_data;
				scrm_pkg::REG_OUT_MAX: out_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	scrm_pkg::cfg_t cfg;

	assign cfg.mode    = mode_q;
	assign cfg.coef_a  = coef_a_q;
	assign cfg.coef_b  = coef_b_q;
	assign cfg.out_min = out_min_q;
	assign cfg.out_max = out_max_q;

	// ---------------- pipeline advance ----------------
	logic out_vld_s14;
	logic adv;

	assign adv          = !out_vld_s14 || out_ch.ready;
	assign in_ch.ready  = adv;

	// ---------------- front end and divider chain ----------------
	logic            vld_d  [NDS+1];
	scrm_pkg::side_t side_d [NDS+1];
	scrm_pkg::div_t  div_d  [NDS+1];

	scrm_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.cfg         (cfg),
		.in_vld      (in_ch.valid),
		.in_present  (in_ch.input_present),
		.in_is_binary(in_ch.input_is_binary),
		.in_level    (in_ch.binary_level),
		.in_sample   (in_ch.sample),
		.vld_o       (vld_d[0]),
		.side_o      (side_d[0]),
		.div_o       (div_d[0])
	);

	for (genvar g = 0; g < NDS; g++) begin : g_div
		scrm_div_stage u_stage (
			.clk   (clk),
			.arst_n(arst_n),
			.adv   (adv),
			.vld_i (vld_d[g]),
			.side_i(side_d[g]),
			.div_i (div_d[g]),
			.vld_o (vld_d[g+1]),
			.side_o(side_d[g+1]),
			.div_o (div_d[g+1])
		);
	end

	// ---------------- output stage: map result and final select ----------------
	logic [DW-1:0] q_c;
	logic [DW-1:0] map_c;
	logic [DW-1:0] res_c;

	assign q_c = div_d[NDS].lo;

	// step from out_min toward out_max; it never leaves the range
	always_comb begin
		case (side_d[NDS].sel)
			scrm_pkg::SEL_MAX: map_c = out_max_q;
			scrm_pkg::SEL_DIV: map_c = side_d[NDS].span_neg ? out_min_q - q_c
			                                                : out_min_q + q_c;
			default:           map_c = out_min_q;
		endcase
		res_c = (side_d[NDS].status == scrm_pkg::ST_MAPPED) ? map_c : side_d[NDS].res;
	end

	logic [DW-1:0] src_s14;
	logic [DW-1:0] res_s14;
	logic          qual_s14;
	logic [1:0]    stat_s14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s14 <= 1'b0;
		end else if (adv) begin
			out_vld_s14 <= vld_d[NDS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			src_s14  <= side_d[NDS].src;
			res_s14  <= res_c;
			qual_s14 <= side_d[NDS].quality;
			stat_s14 <= side_d[NDS].status;
		end
	end

	assign out_ch.valid        = out_vld_s14;
	assign out_ch.source_value = src_s14;
	assign out_ch.result_value = res_s14;
	assign out_ch.quality      = qual_s14;
	assign out_ch.status       = stat_s14;

endmodule

[rtl/scrm_checker.sv]
// Port-level checks for scale_clamp_range_map_top, and the bind that attaches them.
// Depends on scrm_pkg (status codes) and the top level's port names.

module scrm_checker (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_ready,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic [scrm_pkg::DW-1:0] out_source_value,
	input  logic [scrm_pkg::DW-1:0] out_result_value,
	input  logic                    out_quality,
	input  logic [1:0]              out_status
);

	// a result offered and not taken stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before transfer");

	// input side only stalls while a finished result is blocked
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output back-pressure");

	// fault quality goes with the missing status and nothing else
	a_quality: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_quality == (out_status == scrm_pkg::ST_MISSING)))
		else $error("quality and status disagree");

	// a missing input reports zeros
	a_missing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_quality |-> out_source_value == '0 && out_result_value == '0)
		else $error("missing input with non-zero values");

endmodule

bind scale_clamp_range_map_top scrm_checker u_scrm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_ready        (in_ch.ready),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.out_source_value(out_ch.source_value),
	.out_result_value(out_ch.result_value),
	.out_quality     (out_ch.quality),
	.out_status      (out_ch.status)
);
